>>> rtl/drs_pkg.sv
// shared types and constants of the delimited record scanner
// no dependencies; used by drs_regs, delimited_record_scanner and drs_checker
package drs_pkg;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_DATA  = 2'd1,
        KIND_EOF   = 2'd2,
        KIND_RDERR = 2'd3
    } kind_t;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_HEADER = 3'd1;
    localparam logic [2:0] ST_END_NAME   = 3'd2;
    localparam logic [2:0] ST_EMPTY      = 3'd3;
    localparam logic [2:0] ST_READ_ERR   = 3'd4;

    localparam logic [1:0] REG_NAME_LIMIT    = 2'd0;
    localparam logic [1:0] REG_CONTENT_LIMIT = 2'd1;
    localparam logic [1:0] REG_ENTRY_LIMIT   = 2'd2;

    localparam logic [31:0] DELIM_WORD   = 32'h0A3E3E3E;
    localparam logic [16:0] DELIM_SIZE   = 17'd4;
    localparam logic [7:0]  NEWLINE_BYTE = 8'h0A;
    localparam logic [7:0]  MARK_BYTE    = 8'h3E;
    localparam logic [1:0]  HEADER_LEN   = 2'd3;
    localparam logic [31:0] OFFSET_INIT  = 32'd3;

    typedef struct packed {
        logic [7:0]  name_limit;
        logic [15:0] content_limit;
        logic [7:0]  entry_limit;
    } cfg_t;

    typedef struct packed {
        logic        entry_valid;
        logic [7:0]  entry_index;
        logic [31:0] name_start;
        logic [7:0]  name_length;
        logic [31:0] content_start;
        logic [15:0] content_length;
        logic        done_res;
        logic [2:0]  status;
        logic [7:0]  total_entries;
    } res_t;

endpackage

>>> rtl/delimited_record_scanner.sv
// top level of the delimited record scanner: scan state, per-byte logic, result register
// depends on drs_pkg and drs_regs
//
// Takes one stream beat per cycle (start, data byte, end of file, read error) and reports
// each kept record, and the end of the scan, as one result beat. Every beat goes through
// compare, counter and shift logic that updates the scan state and loads any result into the
// result register, so the block sustains one input beat per clock. A result waits there;
// the input keeps being taken while it is free or being drained in the same cycle.
// Limits are set through the register port: name length limit at 0x0, content length limit
// at 0x4, entry limit at 0x8; change them only while the scanner is idle.
module delimited_record_scanner
    import drs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [1:0]  kind,
    input  logic [7:0]  data_byte,
    output logic        res_valid,
    input  logic        res_ready,
    output logic        entry_valid,
    output logic [7:0]  entry_index,
    output logic [31:0] name_start,
    output logic [7:0]  name_length,
    output logic [31:0] content_start,
    output logic [15:0] content_length,
    output logic        done_res,
    output logic [2:0]  status,
    output logic [7:0]  total_entries
);

    cfg_t cfg;

    drs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    logic [1:0]  header_count_reg, header_count_next;
    logic [31:0] recent_bytes_reg, recent_bytes_next;
    logic        in_name_reg, in_name_next;
    logic [31:0] byte_offset_reg, byte_offset_next;
    logic [31:0] name_start_reg, name_start_next;
    logic [7:0]  name_length_reg, name_length_next;
    logic [31:0] content_start_reg, content_start_next;
    logic [16:0] content_length_reg, content_length_next;
    logic [7:0]  entry_count_reg, entry_count_next;
    logic        finished_reg, finished_next;
    logic        res_valid_reg;
    res_t        res_reg;

    res_t        res_new;
    logic        has_res;
    logic        accept;
    logic [31:0] shifted;
    logic [7:0]  nl_inc;
    logic [16:0] cl_inc;
    logic [16:0] cl_trim;
    logic [16:0] cl_limit;
    logic [7:0]  count_inc;
    logic        delim_hit;

    assign accept     = item_valid & item_ready;
    assign item_ready = ~res_valid_reg | res_ready;
    assign shifted    = {recent_bytes_reg[23:0], data_byte};
    assign cl_limit   = {1'b0, cfg.content_limit};
    assign count_inc  = entry_count_reg + 8'd1;
    assign nl_inc     = (name_length_reg < cfg.name_limit) ? name_length_reg + 8'd1
                                                           : name_length_reg;
    assign cl_inc     = (content_length_reg <= cl_limit) ? content_length_reg + 17'd1
                                                         : content_length_reg;
    assign cl_trim    = (cl_inc < DELIM_SIZE) ? 17'd0 : cl_inc - DELIM_SIZE;
    assign delim_hit  = ~in_name_reg & (shifted == DELIM_WORD);

    always_comb
    begin
        header_count_next   = header_count_reg;
        recent_bytes_next   = recent_bytes_reg;
        in_name_next        = in_name_reg;
        byte_offset_next    = byte_offset_reg;
        name_start_next     = name_start_reg;
        name_length_next    = name_length_reg;
        content_start_next  = content_start_reg;
        content_length_next = content_length_reg;
        entry_count_next    = entry_count_reg;
        finished_next       = finished_reg;
        res_new             = '0;
        has_res             = 1'b0;

        if (kind == KIND_START)
        begin
            header_count_next   = 2'd0;
            recent_bytes_next   = 32'd0;
            in_name_next        = 1'b1;
            byte_offset_next    = OFFSET_INIT;
            name_start_next     = OFFSET_INIT;
            name_length_next    = 8'd0;
            content_start_next  = 32'd0;
            content_length_next = 17'd0;
            entry_count_next    = 8'd0;
            finished_next       = 1'b0;
        end
        else if (!finished_reg)
        begin
            if (header_count_reg < HEADER_LEN)
            begin
                if (kind == KIND_DATA && data_byte == MARK_BYTE)
                begin
                    header_count_next = header_count_reg + 2'd1;
                    recent_bytes_next = shifted;
                end
                else
                begin
                    finished_next         = 1'b1;
                    has_res               = 1'b1;
                    res_new.done_res      = 1'b1;
                    res_new.status        = ST_BAD_HEADER;
                    res_new.total_entries = entry_count_reg;
                end
            end
            else if (kind == KIND_RDERR)
            begin
                finished_next         = 1'b1;
                has_res               = 1'b1;
                res_new.done_res      = 1'b1;
                res_new.status        = ST_READ_ERR;
                res_new.total_entries = entry_count_reg;
            end
            else if (kind == KIND_EOF)
            begin
                finished_next         = 1'b1;
                has_res               = 1'b1;
                res_new.done_res      = 1'b1;
                res_new.total_entries = entry_count_reg;
                if (in_name_reg)
                begin
                    res_new.status = ST_END_NAME;
                end
                else if (content_length_reg == 17'd0 || name_length_reg == 8'd0)
                begin
                    res_new.status = ST_EMPTY;
                end
                else
                begin
                    res_new.status = ST_OK;
                    if (content_length_reg <= cl_limit)
                    begin
                        res_new.entry_valid    = 1'b1;
                        res_new.entry_index    = entry_count_reg;
                        res_new.name_start     = name_start_reg;
                        res_new.name_length    = name_length_reg;
                        res_new.content_start  = content_start_reg;
                        res_new.content_length = content_length_reg[15:0];
                        res_new.total_entries  = count_inc;
                        entry_count_next       = count_inc;
                    end
                end
            end
            else
            begin
                // data byte inside the records
                recent_bytes_next = shifted;
                byte_offset_next  = byte_offset_reg + 32'd1;
                if (in_name_reg)
                begin
                    name_length_next = nl_inc;
                end
                else
                begin
                    content_length_next = cl_inc;
                end

                if (delim_hit)
                begin
                    if (cl_inc <= cl_limit && (cl_trim == 17'd0 || name_length_reg == 8'd0))
                    begin
                        finished_next         = 1'b1;
                        has_res               = 1'b1;
                        res_new.done_res      = 1'b1;
                        res_new.status        = ST_EMPTY;
                        res_new.total_entries = entry_count_reg;
                    end
                    else
                    begin
                        if (cl_inc <= cl_limit)
                        begin
                            has_res                = 1'b1;
                            res_new.entry_valid    = 1'b1;
                            res_new.entry_index    = entry_count_reg;
                            res_new.name_start     = name_start_reg;
                            res_new.name_length    = name_length_reg;
                            res_new.content_start  = content_start_reg;
                            res_new.content_length = cl_trim[15:0];
                            res_new.total_entries  = count_inc;
                            entry_count_next       = count_inc;
                        end
                        if (entry_count_next >= cfg.entry_limit)
                        begin
                            finished_next         = 1'b1;
                            has_res               = 1'b1;
                            res_new.done_res      = 1'b1;
                            res_new.status        = ST_OK;
                            res_new.total_entries = entry_count_next;
                        end
                        else
                        begin
                            name_start_next     = byte_offset_reg + 32'd1;
                            name_length_next    = 8'd0;
                            content_start_next  = 32'd0;
                            content_length_next = 17'd0;
                            in_name_next        = 1'b1;
                        end
                    end
                end
                else if (in_name_reg && data_byte == NEWLINE_BYTE)
                begin
                    in_name_next       = 1'b0;
                    name_length_next   = (nl_inc != 8'd0) ? nl_inc - 8'd1 : 8'd0;
                    content_start_next = byte_offset_reg + 32'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_count_reg   <= 2'd0;
            recent_bytes_reg   <= 32'd0;
            in_name_reg        <= 1'b1;
            byte_offset_reg    <= OFFSET_INIT;
            name_start_reg     <= OFFSET_INIT;
            name_length_reg    <= 8'd0;
            content_start_reg  <= 32'd0;
            content_length_reg <= 17'd0;
            entry_count_reg    <= 8'd0;
            finished_reg       <= 1'b1;
        end
        else if (accept)
        begin
            header_count_reg   <= header_count_next;
            recent_bytes_reg   <= recent_bytes_next;
            in_name_reg        <= in_name_next;
            byte_offset_reg    <= byte_offset_next;
            name_start_reg     <= name_start_next;
            name_length_reg    <= name_length_next;
            content_start_reg  <= content_start_next;
            content_length_reg <= content_length_next;
            entry_count_reg    <= entry_count_next;
            finished_reg       <= finished_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (accept && has_res)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && has_res)
        begin
            res_reg <= res_new;
        end
    end

    assign res_valid      = res_valid_reg;
    assign entry_valid    = res_reg.entry_valid;
    assign entry_index    = res_reg.entry_index;
    assign name_start     = res_reg.name_start;
    assign name_length    = res_reg.name_length;
    assign content_start  = res_reg.content_start;
    assign content_length = res_reg.content_length;
    assign done_res       = res_reg.done_res;
    assign status         = res_reg.status;
    assign total_entries  = res_reg.total_entries;

endmodule

>>> rtl/drs_regs.sv
// configuration registers of the delimited record scanner behind an apb-style port
// depends on drs_pkg
module drs_regs
    import drs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.name_limit    <= 8'd32;
            cfg_reg.content_limit <= 16'd4096;
            cfg_reg.entry_limit   <= 8'd16;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_NAME_LIMIT:    cfg_reg.name_limit    <= pwdata[7:0];
                REG_CONTENT_LIMIT: cfg_reg.content_limit <= pwdata[15:0];
                REG_ENTRY_LIMIT:   cfg_reg.entry_limit   <= pwdata[7:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_NAME_LIMIT:    prdata = {24'd0, cfg_reg.name_limit};
            REG_CONTENT_LIMIT: prdata = {16'd0, cfg_reg.content_limit};
            REG_ENTRY_LIMIT:   prdata = {24'd0, cfg_reg.entry_limit};
            default:           prdata = 32'd0;
        endcase
    end

endmodule

>>> rtl/drs_checker.sv
// port-level checks of the delimited record scanner, bound to the top level
// depends on drs_pkg and delimited_record_scanner
module drs_checker
    import drs_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic        entry_valid,
    input logic [7:0]  entry_index,
    input logic [31:0] name_start,
    input logic [7:0]  name_length,
    input logic [31:0] content_start,
    input logic [15:0] content_length,
    input logic        done_res,
    input logic [2:0]  status,
    input logic [7:0]  total_entries
);

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(entry_index)
            && $stable(total_entries) && $stable(status) && $stable(done_res))
        else $error("result beat changed while stalled");

    // no record fields without a record
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !entry_valid |-> entry_index == 8'd0 && name_start == 32'd0
            && name_length == 8'd0 && content_start == 32'd0 && content_length == 16'd0)
        else $error("record fields set without a record");

    // a record or an end of scan in every beat, status only at the end
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (entry_valid || done_res) && (done_res || status == ST_OK))
        else $error("empty result beat or stray status");

    // a reported record is counted and not empty
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && entry_valid |-> total_entries == entry_index + 8'd1
            && content_length != 16'd0)
        else $error("record count or length inconsistent");

endmodule

bind delimited_record_scanner drs_checker u_drs_checker (.*);

>>> bench/delimited_record_scanner_test.sv
`timescale 1ns / 1ps
// self-checking testbench of delimited_record_scanner: driver and monitor blocks around
// a built-in scan predictor; depends on drs_pkg and the scanner rtl only
module delimited_record_scanner_test;
    import drs_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int SHOWN_ERRORS = 10;

    typedef struct packed {
        kind_t      k;
        logic [7:0] b;
    } stream_beat_t;

    typedef enum int {
        SHAPE_CLEAN,
        SHAPE_BAD_HEADER,
        SHAPE_END_IN_NAME,
        SHAPE_EMPTY_NAME,
        SHAPE_EMPTY_BODY,
        SHAPE_READ_ERR
    } scan_shape_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        item_valid = 1'b0;
    logic        item_ready;
    logic [1:0]  kind = KIND_START;
    logic [7:0]  data_byte = '0;
    logic        res_valid;
    logic        res_ready = 1'b0;
    logic        entry_valid;
    logic [7:0]  entry_index;
    logic [31:0] name_start;
    logic [7:0]  name_length;
    logic [31:0] content_start;
    logic [15:0] content_length;
    logic        done_res;
    logic [2:0]  status;
    logic [7:0]  total_entries;

    delimited_record_scanner dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .kind          (kind),
        .data_byte     (data_byte),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .entry_valid   (entry_valid),
        .entry_index   (entry_index),
        .name_start    (name_start),
        .name_length   (name_length),
        .content_start (content_start),
        .content_length(content_length),
        .done_res      (done_res),
        .status        (status),
        .total_entries (total_entries)
    );

    always #6 clk = ~clk;

    stream_beat_t pending_q[$];
    res_t         record_reports_q[$];
    int           queued_items = 0;
    int           mismatches = 0;
    int           quiet_cycles = 0;
    int           in_hold = 0;
    int           out_hold = 0;
    bit           in_steady = 1'b0;
    bit           out_steady = 1'b0;
    bit           beat_taken = 1'b0;

    // predictor state
    cfg_t        lim;
    logic [1:0]  hdr_seen;
    logic [31:0] last_four;
    logic        naming;
    logic [31:0] offset;
    logic [31:0] name_at;
    logic [7:0]  name_len;
    logic [31:0] content_at;
    logic [16:0] content_len;
    logic [7:0]  records;
    logic        scan_idle;

    task automatic clear_scan_state();
        hdr_seen = '0;
        last_four = '0;
        naming = 1'b1;
        offset = OFFSET_INIT;
        name_at = OFFSET_INIT;
        name_len = '0;
        content_at = '0;
        content_len = '0;
        records = '0;
    endtask

    task automatic close_scan(inout res_t r, input logic [2:0] code);
        scan_idle = 1'b1;
        r.done_res = 1'b1;
        r.status = code;
    endtask

    task automatic add_record(inout res_t r);
        r.entry_valid = 1'b1;
        r.entry_index = records;
        r.name_start = name_at;
        r.name_length = name_len;
        r.content_start = content_at;
        r.content_length = content_len[15:0];
        records = records + 8'd1;
    endtask

    task automatic scan_beat(input kind_t k, input logic [7:0] b);
        res_t r;
        r = '0;
        if (k == KIND_START)
        begin
            clear_scan_state();
            scan_idle = 1'b0;
        end
        else if (!scan_idle)
        begin
            if (hdr_seen < HEADER_LEN)
            begin
                if (k == KIND_DATA && b == MARK_BYTE)
                begin
                    hdr_seen = hdr_seen + 2'd1;
                    last_four = {last_four[23:0], b};
                end
                else
                    close_scan(r, ST_BAD_HEADER);
            end
            else if (k == KIND_RDERR)
                close_scan(r, ST_READ_ERR);
            else if (k == KIND_EOF)
            begin
                if (naming)
                    close_scan(r, ST_END_NAME);
                else if (content_len == 0 || name_len == 0)
                    close_scan(r, ST_EMPTY);
                else
                begin
                    if (content_len <= lim.content_limit)
                        add_record(r);
                    close_scan(r, ST_OK);
                end
            end
            else
            begin
                last_four = {last_four[23:0], b};
                if (naming)
                begin
                    if (name_len < lim.name_limit)
                        name_len = name_len + 8'd1;
                end
                else if (content_len <= lim.content_limit)
                    content_len = content_len + 17'd1;
                if (!naming && last_four == DELIM_WORD)
                begin
                    if (content_len <= lim.content_limit)
                    begin
                        // content shorter than the delimiter counts as empty
                        content_len = (content_len < DELIM_SIZE) ? '0 : content_len - DELIM_SIZE;
                        if (content_len == 0 || name_len == 0)
                            close_scan(r, ST_EMPTY);
                        else
                            add_record(r);
                    end
                    if (!r.done_res && records >= lim.entry_limit)
                        close_scan(r, ST_OK);
                    if (!r.done_res)
                    begin
                        name_at = offset + 32'd1;
                        name_len = '0;
                        content_at = '0;
                        content_len = '0;
                        naming = 1'b1;
                    end
                end
                if (!r.done_res)
                begin
                    if (b == NEWLINE_BYTE && naming)
                    begin
                        naming = 1'b0;
                        if (name_len > 0)
                            name_len = name_len - 8'd1;
                        content_at = offset + 32'd1;
                    end
                    offset = offset + 32'd1;
                end
            end
            if (r.entry_valid || r.done_res)
            begin
                r.total_entries = records;
                record_reports_q.push_back(r);
            end
        end
    endtask

    function automatic string show(input res_t r);
        return $sformatf("v=%0d idx=%0d ns=%0d nl=%0d cs=%0d cl=%0d done=%0d st=%0d tot=%0d",
            r.entry_valid, r.entry_index, r.name_start, r.name_length, r.content_start,
            r.content_length, r.done_res, r.status, r.total_entries);
    endfunction

    task automatic flag_result(input string why, input res_t want, input res_t got);
        mismatches++;
        if (mismatches <= SHOWN_ERRORS)
            $display("%s: expected %s / got %s", why, show(want), show(got));
    endtask

    function automatic int pause_len(input bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // input side: one beat held until taken, random gaps between beats
    always @(negedge clk)
    begin : feed
        stream_beat_t nb;
        if (!item_valid || beat_taken)
        begin
            beat_taken = 1'b0;
            if (in_hold > 0)
            begin
                in_hold--;
                item_valid <= 1'b0;
            end
            else if (pending_q.size() != 0)
            begin
                nb = pending_q.pop_front();
                kind <= nb.k;
                data_byte <= nb.b;
                item_valid <= 1'b1;
                in_hold = pause_len(in_steady);
                if ($urandom_range(0, 39) == 0)
                    in_steady = !in_steady;
            end
            else
                item_valid <= 1'b0;
        end
    end

    // result side back-pressure
    always @(negedge clk)
    begin
        if (out_hold > 0)
        begin
            out_hold--;
            res_ready <= 1'b0;
        end
        else
        begin
            res_ready <= 1'b1;
            out_hold = pause_len(out_steady);
            if ($urandom_range(0, 49) == 0)
                out_steady = !out_steady;
        end
    end

    always @(posedge clk)
    begin : watch
        res_t got;
        if (rst_n)
        begin
            if (item_valid && item_ready)
            begin
                scan_beat(kind_t'(kind), data_byte);
                beat_taken = 1'b1;
            end
            if (res_valid && res_ready)
            begin
                got = {entry_valid, entry_index, name_start, name_length, content_start,
                       content_length, done_res, status, total_entries};
                if (record_reports_q.size() == 0)
                    flag_result("unexpected result", '0, got);
                else if (got !== record_reports_q[0])
                    flag_result("result mismatch", record_reports_q.pop_front(), got);
                else
                    void'(record_reports_q.pop_front());
            end
        end
        if ((item_valid && item_ready) || (res_valid && res_ready) || psel)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("FAIL delimited_record_scanner");
            $finish;
        end
    end

    task automatic reg_access(input logic wr, input logic [1:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (!wr && prdata !== val)
        begin
            mismatches++;
            if (mismatches <= SHOWN_ERRORS)
                $display("register %0d read back %h, expected %h", idx, prdata, val);
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic write_limit(input logic [1:0] idx, input logic [31:0] val);
        reg_access(1'b1, idx, val);
        case (idx)
            REG_NAME_LIMIT:    lim.name_limit = val[7:0];
            REG_CONTENT_LIMIT: lim.content_limit = val[15:0];
            default:           lim.entry_limit = val[7:0];
        endcase
        reg_access(1'b0, idx, val);
    endtask

    task automatic set_limits(input logic [7:0] n, input logic [15:0] c, input logic [7:0] e);
        write_limit(REG_NAME_LIMIT, {24'd0, n});
        write_limit(REG_CONTENT_LIMIT, {16'd0, c});
        write_limit(REG_ENTRY_LIMIT, {24'd0, e});
    endtask

    task automatic add_item(input kind_t k, input logic [7:0] b);
        pending_q.push_back({k, b});
        queued_items++;
    endtask

    function automatic logic [7:0] stream_byte(input int newline_pct);
        int r;
        logic [7:0] v;
        r = $urandom_range(0, 99);
        v = 8'($urandom);
        if (r < newline_pct)
            return NEWLINE_BYTE;
        if (r < newline_pct + 15 || v == NEWLINE_BYTE)
            return MARK_BYTE;
        return v;
    endfunction

    task automatic add_delimiter();
        add_item(KIND_DATA, NEWLINE_BYTE);
        repeat (3) add_item(KIND_DATA, MARK_BYTE);
    endtask

    task automatic queue_scan(input scan_shape_t shape);
        int recs;
        int nl;
        int cl;
        bit closing;
        logic [7:0] v;
        add_item(KIND_START, 8'($urandom));
        if (shape == SHAPE_BAD_HEADER)
        begin
            repeat ($urandom_range(0, 2)) add_item(KIND_DATA, MARK_BYTE);
            v = 8'($urandom);
            if (v == MARK_BYTE)
                v = 8'h00;
            case ($urandom_range(0, 2))
                0:       add_item(KIND_DATA, v);
                1:       add_item(KIND_EOF, 8'($urandom));
                default: add_item(KIND_RDERR, 8'($urandom));
            endcase
        end
        else
        begin
            repeat (3) add_item(KIND_DATA, MARK_BYTE);
            recs = $urandom_range(1, 20);
            for (int i = 0; i < recs; i++)
            begin
                closing = (i == recs - 1);
                nl = ($urandom_range(0, 49) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 6);
                if (closing && shape == SHAPE_EMPTY_NAME)
                    nl = 0;
                repeat (nl) add_item(KIND_DATA, stream_byte(0));
                if (closing && shape == SHAPE_END_IN_NAME)
                begin
                    add_item(KIND_EOF, 8'($urandom));
                    break;
                end
                add_item(KIND_DATA, NEWLINE_BYTE);
                cl = ($urandom_range(0, 29) == 0) ? $urandom_range(1, 80) : $urandom_range(1, 10);
                if (closing && shape == SHAPE_EMPTY_BODY)
                begin
                    // either a bare delimiter or one sharing the name's newline
                    if ($urandom_range(0, 1) == 0)
                        add_item(KIND_DATA, NEWLINE_BYTE);
                    repeat (3) add_item(KIND_DATA, MARK_BYTE);
                    break;
                end
                repeat (cl) add_item(KIND_DATA, stream_byte(10));
                if (closing && shape == SHAPE_READ_ERR)
                begin
                    add_item(KIND_RDERR, 8'($urandom));
                    break;
                end
                if (closing)
                    add_item(KIND_EOF, 8'($urandom));
                else
                    add_delimiter();
            end
        end
    endtask

    task automatic fill_scans(input int budget);
        int goal;
        int r;
        goal = queued_items + budget;
        while (queued_items < goal)
        begin
            // stray beats, mostly ignored by an idle scanner
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 5))
                    pending_q.push_back({kind_t'($urandom_range(0, 3)), 8'($urandom)});
            r = $urandom_range(0, 99);
            if (r < 60)
                queue_scan(SHAPE_CLEAN);
            else if (r < 66)
                queue_scan(SHAPE_BAD_HEADER);
            else if (r < 72)
                queue_scan(SHAPE_END_IN_NAME);
            else if (r < 78)
                queue_scan(SHAPE_EMPTY_NAME);
            else if (r < 86)
                queue_scan(SHAPE_EMPTY_BODY);
            else
                queue_scan(SHAPE_READ_ERR);
        end
    endtask

    task automatic settle();
        do
            @(posedge clk);
        while (pending_q.size() != 0 || item_valid || record_reports_q.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin : run
        lim = {8'd32, 16'd4096, 8'd16};
        clear_scan_state();
        scan_idle = 1'b1;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // beats before any start
        add_item(KIND_DATA, 8'hFF);
        add_item(KIND_EOF, 8'h00);
        add_item(KIND_RDERR, 8'hA5);
        // bad header by byte, by read error, by end of file
        add_item(KIND_START, 8'h00);
        add_item(KIND_DATA, MARK_BYTE);
        add_item(KIND_DATA, 8'h00);
        add_item(KIND_START, 8'hFF);
        add_item(KIND_RDERR, 8'h00);
        add_item(KIND_START, 8'h00);
        add_item(KIND_DATA, MARK_BYTE);
        add_item(KIND_EOF, 8'hFF);
        // one record closed by end of file
        add_item(KIND_START, 8'h00);
        repeat (3) add_item(KIND_DATA, MARK_BYTE);
        add_item(KIND_DATA, 8'h6E);
        add_item(KIND_DATA, NEWLINE_BYTE);
        add_item(KIND_DATA, 8'h63);
        add_item(KIND_EOF, 8'h00);
        // empty name whose newline is also the delimiter
        add_item(KIND_START, 8'h00);
        repeat (3) add_item(KIND_DATA, MARK_BYTE);
        add_item(KIND_DATA, NEWLINE_BYTE);
        repeat (3) add_item(KIND_DATA, MARK_BYTE);
        fill_scans(60);
        settle();

        for (int phase = 1; phase <= 7; phase++)
        begin
            case (phase)
                1:       set_limits(8'd1, 16'd1, 8'd1);
                2:       set_limits(8'd255, 16'd65535, 8'd255);
                3:       set_limits(8'd4, 16'd12, 8'd3);
                4:       set_limits(8'd8, 16'd30, 8'd6);
                5:       set_limits(8'd2, 16'd3, 8'd40);
                6:       set_limits(8'd255, 16'd200, 8'd1);
                default: set_limits(8'($urandom_range(1, 255)), 16'($urandom_range(1, 65535)),
                                    8'($urandom_range(1, 255)));
            endcase
            fill_scans(60);
            settle();
        end

        if (mismatches == 0 && record_reports_q.size() == 0)
            $display("PASS delimited_record_scanner");
        else
            $display("FAIL delimited_record_scanner");
        $finish;
    end

endmodule
